[rtl/paged_array_slot_directory_core_macros.svh]
// assertion macros shared by the paged array slot directory rtl
// no dependencies; included by the files that carry assertions
`ifndef PAGED_ARRAY_SLOT_DIRECTORY_CORE_MACROS_SVH
`define PAGED_ARRAY_SLOT_DIRECTORY_CORE_MACROS_SVH

// antecedent in a cycle implies consequent in the same cycle
`define PASD_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent in a cycle implies consequent in the next cycle
`define PASD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// condition holds at every clock edge out of reset
`define PASD_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

`endif

[rtl/pasd_pkg.sv]
// types and constants of the paged array slot directory
// no dependencies; used by the interfaces and the top level
package pasd_pkg;

   localparam int PAGE_WORDS = 128;
   localparam int SLOT_COUNT = 4;
   localparam int MAX_PAGES  = 131072;

   localparam int OFF_W   = $clog2(PAGE_WORDS);
   localparam int SLOT_W  = $clog2(SLOT_COUNT);
   localparam int PAGE_W  = $clog2(MAX_PAGES);
   localparam int SIZE_W  = 25;
   localparam int WORD_W  = 32;
   localparam int CNT_W   = 32;
   localparam int LFSR_W  = 16;
   localparam int CSR_AW  = 3;

   localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
   localparam logic [LFSR_W-1:0] LFSR_SEED = 16'h0001;

   // register index, taken from the word part of the byte address
   localparam logic REG_ARRAY_SIZE = 1'b0;

   typedef enum logic [1:0] {
      ST_HIT   = 2'd0,
      ST_FAULT = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

endpackage

[rtl/pasd_if.sv]
// request and response channel interfaces of the slot directory
// depends on pasd_pkg
interface pasd_req_if import pasd_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     func;
   logic signed [WORD_W-1:0] index;
   logic signed [WORD_W-1:0] value;

   modport source (output valid, output func, output index, output value, input ready);
   modport sink   (input valid, input func, input index, input value, output ready);
endinterface

interface pasd_rsp_if import pasd_pkg::*; ();
   logic                     valid;
   logic                     ready;
   status_type               status;
   logic [SLOT_W-1:0]        slot;
   logic [OFF_W-1:0]         offset;
   logic [PAGE_W-1:0]        fill_page;
   logic                     evict_valid;
   logic [PAGE_W-1:0]        evict_page;
   logic                     write_enable;
   logic signed [WORD_W-1:0] write_data;
   logic [CNT_W-1:0]         hit_count;
   logic [CNT_W-1:0]         fault_count;

   modport source (output valid, output status, output slot, output offset,
                   output fill_page, output evict_valid, output evict_page,
                   output write_enable, output write_data, output hit_count,
                   output fault_count, input ready);
   modport sink   (input valid, input status, input slot, input offset,
                   input fill_page, input evict_valid, input evict_page,
                   input write_enable, input write_data, input hit_count,
                   input fault_count, output ready);
endinterface

[rtl/paged_array_slot_directory_core.sv]
// top level of the paged array slot directory: tag compare, fill and evict
// depends on pasd_pkg, pasd_if.sv and paged_array_slot_directory_core_macros.svh
//
//   channel   kind      handshake          content
//   req_bus   sink      valid/ready        func, index, value
//   rsp_bus   source    valid/ready        status, slot, offset, fill/evict, write, counters
//   csr_*     apb slave psel/penable/pwrite array_size at byte address 0
//
// one access per clock while the response side does not stall: request register, then tag
// compare and slot choice into the response register
// the request register refills in the cycle the response register moves,
// so a stalled response holds back only one waiting request
// synchronous active-high reset clears all valid bits, counters, array_size; seeds the lfsr
// no clearing pass: slot tags are only read behind their valid bits
`include "paged_array_slot_directory_core_macros.svh"

module paged_array_slot_directory_core import pasd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   pasd_req_if.sink          req_bus,
   pasd_rsp_if.source        rsp_bus,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [WORD_W-1:0] csr_pwdata,
   output logic [WORD_W-1:0] csr_prdata,
   output logic              csr_pready
);

   // configuration register
   logic [SIZE_W-1:0] array_size_ff;

   // request register
   logic                     in_valid_ff;
   logic                     in_func_ff;
   logic signed [WORD_W-1:0] in_index_ff;
   logic signed [WORD_W-1:0] in_value_ff;

   // directory state
   logic [SLOT_COUNT-1:0] slot_valid_ff;
   logic [PAGE_W-1:0]     slot_page_ff [SLOT_COUNT];
   logic [CNT_W-1:0]      hits_ff;
   logic [CNT_W-1:0]      faults_ff;
   logic [LFSR_W-1:0]     lfsr_ff;

   // response register
   logic                     out_valid_ff;
   status_type               status_ff, status_in;
   logic [SLOT_W-1:0]        slot_ff, slot_in;
   logic [OFF_W-1:0]         offset_ff, offset_in;
   logic [PAGE_W-1:0]        fill_page_ff, fill_page_in;
   logic                     evict_valid_ff, evict_valid_in;
   logic [PAGE_W-1:0]        evict_page_ff, evict_page_in;
   logic                     write_enable_ff, write_enable_in;
   logic signed [WORD_W-1:0] write_data_ff, write_data_in;

   // next values of the directory state
   logic [CNT_W-1:0]  hits_in, faults_in;
   logic [LFSR_W-1:0] lfsr_in;

   // compare and choice signals
   logic                  advance;
   logic                  in_range;
   logic [PAGE_W-1:0]     page;
   logic [SLOT_COUNT-1:0] hit_vec;
   logic                  any_hit;
   logic [SLOT_W-1:0]     hit_slot;
   logic                  any_empty;
   logic [SLOT_W-1:0]     empty_slot;
   logic [SLOT_W-1:0]     victim_slot;
   logic [SLOT_W-1:0]     fill_slot;
   logic                  do_fill;
   logic                  csr_write;

   // the request register moves on when the response register is free or draining
   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;

   // apb slave, no wait states
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[CSR_AW-1] == REG_ARRAY_SIZE) ?
                       {{(WORD_W-SIZE_W){1'b0}}, array_size_ff} : '0;

   // index split and bounds check; an in-range index can reach 2^25 - 2, but the
   // tag keeps only index bits 23 to 7, so pages above that range alias
   always_comb begin
      in_range = !in_index_ff[WORD_W-1] &&
                 ({1'b0, in_index_ff[WORD_W-2:0]} < {{(WORD_W-SIZE_W){1'b0}}, array_size_ff});
      page     = in_index_ff[OFF_W+PAGE_W-1:OFF_W];
   end

   // tag compare and slot choice, lowest slot wins
   always_comb begin
      hit_vec    = '0;
      any_hit    = 1'b0;
      hit_slot   = '0;
      any_empty  = 1'b0;
      empty_slot = '0;
      for (int s = 0; s < SLOT_COUNT; s++) begin
         hit_vec[s] = slot_valid_ff[s] && (slot_page_ff[s] == page);
      end
      for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
         if (hit_vec[s]) begin
            any_hit  = 1'b1;
            hit_slot = SLOT_W'(s);
         end
         if (!slot_valid_ff[s]) begin
            any_empty  = 1'b1;
            empty_slot = SLOT_W'(s);
         end
      end
      // slot count is a power of two, so the modulo is the low lfsr bits
      victim_slot = lfsr_ff[SLOT_W-1:0];
      fill_slot   = any_empty ? empty_slot : victim_slot;
      do_fill     = in_range && !any_hit;
   end

   // response fields and next counter values
   always_comb begin
      status_in       = ST_RANGE;
      slot_in         = '0;
      offset_in       = '0;
      fill_page_in    = '0;
      evict_valid_in  = 1'b0;
      evict_page_in   = '0;
      write_enable_in = 1'b0;
      write_data_in   = '0;
      hits_in         = hits_ff;
      faults_in       = faults_ff;
      lfsr_in         = lfsr_ff;
      if (in_range) begin
         offset_in = in_index_ff[OFF_W-1:0];
         if (any_hit) begin
            status_in = ST_HIT;
            slot_in   = hit_slot;
            if (!in_func_ff) begin
               hits_in = hits_ff + 1'b1;
            end
         end else begin
            status_in    = ST_FAULT;
            slot_in      = fill_slot;
            fill_page_in = page;
            if (!any_empty) begin
               // every slot busy: evict and step the galois lfsr
               evict_valid_in = 1'b1;
               evict_page_in  = slot_page_ff[victim_slot];
               lfsr_in        = {1'b0, lfsr_ff[LFSR_W-1:1]} ^
                                (lfsr_ff[0] ? LFSR_TAPS : '0);
            end
            if (!in_func_ff) begin
               faults_in = faults_ff + 1'b1;
            end
         end
         if (in_func_ff) begin
            write_enable_in = 1'b1;
            write_data_in   = in_value_ff;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         array_size_ff <= '0;
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         slot_valid_ff <= '0;
         hits_ff       <= '0;
         faults_ff     <= '0;
         lfsr_ff       <= LFSR_SEED;
      end else begin
         if (csr_write && (csr_paddr[CSR_AW-1] == REG_ARRAY_SIZE)) begin
            array_size_ff <= csr_pwdata[SIZE_W-1:0];
         end
         if (req_bus.ready) begin
            in_valid_ff <= req_bus.valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            hits_ff      <= hits_in;
            faults_ff    <= faults_in;
            lfsr_ff      <= lfsr_in;
            if (do_fill) begin
               slot_valid_ff[fill_slot] <= 1'b1;
            end
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         in_func_ff  <= req_bus.func;
         in_index_ff <= req_bus.index;
         in_value_ff <= req_bus.value;
      end
      if (advance) begin
         status_ff       <= status_in;
         slot_ff         <= slot_in;
         offset_ff       <= offset_in;
         fill_page_ff    <= fill_page_in;
         evict_valid_ff  <= evict_valid_in;
         evict_page_ff   <= evict_page_in;
         write_enable_ff <= write_enable_in;
         write_data_ff   <= write_data_in;
         if (do_fill) begin
            slot_page_ff[fill_slot] <= page;
         end
      end
   end

   // counters change only when a response is loaded, so while it waits they
   // still hold the values after that access
   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.status       = status_ff;
   assign rsp_bus.slot         = slot_ff;
   assign rsp_bus.offset       = offset_ff;
   assign rsp_bus.fill_page    = fill_page_ff;
   assign rsp_bus.evict_valid  = evict_valid_ff;
   assign rsp_bus.evict_page   = evict_page_ff;
   assign rsp_bus.write_enable = write_enable_ff;
   assign rsp_bus.write_data   = write_data_ff;
   assign rsp_bus.hit_count    = hits_ff;
   assign rsp_bus.fault_count  = faults_ff;

   // lfsr must never lock up at zero
   `PASD_ASSERT_ALWAYS(a_lfsr_nonzero, clock, reset, lfsr_ff != '0, "lfsr reached zero")

   // an eviction is only issued with a fault
   `PASD_ASSERT_IMPLIES(a_evict_fault, clock, reset, out_valid_ff && evict_valid_ff,
      status_ff == ST_FAULT, "eviction without fault")

   // an out-of-range access issues no write and no eviction
   `PASD_ASSERT_IMPLIES(a_range_quiet, clock, reset, out_valid_ff && (status_ff == ST_RANGE),
      !write_enable_ff && !evict_valid_ff && (fill_page_ff == '0), "range error not quiet")

   // a read hit advances the hit counter by one
   `PASD_ASSERT_NEXT(a_hit_count, clock, reset, advance && in_range && any_hit && !in_func_ff,
      hits_ff == $past(hits_ff) + 1'b1, "hit counter did not advance")

   // a fault fills a slot that is valid afterwards
   `PASD_ASSERT_NEXT(a_fill_valid, clock, reset, advance && do_fill,
      slot_valid_ff[$past(fill_slot)], "filled slot not valid")

endmodule

[tb/pasd_directory_checker.sv]
// checker for the paged array slot directory: watches the request, response and csr ports
// keeps its own copy of slot tags, counters, victim lfsr and array_size to predict each response
// depends on pasd_pkg and the channel interfaces in pasd_if.sv
module pasd_directory_checker import pasd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   pasd_req_if               req_mon,
   pasd_rsp_if               rsp_mon,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [WORD_W-1:0] csr_pwdata,
   input  logic              csr_pready,
   output int                pending_results,
   output int                mismatch_count
);

   typedef struct packed {
      status_type          status;
      logic [SLOT_W-1:0]   slot;
      logic [OFF_W-1:0]    offset;
      logic [PAGE_W-1:0]   fill_page;
      logic                evict_valid;
      logic [PAGE_W-1:0]   evict_page;
      logic                write_enable;
      logic [WORD_W-1:0]   write_data;
      logic [CNT_W-1:0]    hit_count;
      logic [CNT_W-1:0]    fault_count;
   } access_result_type;

   logic [SIZE_W-1:0] bound_words;
   logic              tag_valid [SLOT_COUNT];
   logic [PAGE_W-1:0] tag_page  [SLOT_COUNT];
   logic [CNT_W-1:0]  hit_total;
   logic [CNT_W-1:0]  fault_total;
   logic [LFSR_W-1:0] victim_lfsr;
   access_result_type expected_accesses [$];

   initial begin
      mismatch_count  = 0;
      pending_results = 0;
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("[%0t] response mismatch: %s", $time, msg);
   endtask

   task automatic compare_field(input string name, input logic [WORD_W-1:0] got,
                                input logic [WORD_W-1:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %h expected %h", name, got, want));
      end
   endtask

   // one access through the directory: bounds check, tag match, fill or evict
   function automatic access_result_type predict_access(input logic is_write,
                                                        input logic [WORD_W-1:0] idx,
                                                        input logic [WORD_W-1:0] wdata);
      access_result_type r;
      logic [PAGE_W-1:0] page;
      logic              lsb;
      int                found;
      int                target;
      r = '0;
      if (idx[WORD_W-1] || idx >= WORD_W'(bound_words)) begin
         r.status = ST_RANGE;
      end else begin
         page  = idx[OFF_W +: PAGE_W];
         found = -1;
         for (int s = 0; s < SLOT_COUNT; s++) begin
            if (found < 0 && tag_valid[s] && tag_page[s] == page) found = s;
         end
         if (found >= 0) begin
            r.status = ST_HIT;
            r.slot   = SLOT_W'(found);
            if (!is_write) hit_total++;
         end else begin
            target = -1;
            for (int s = 0; s < SLOT_COUNT; s++) begin
               if (target < 0 && !tag_valid[s]) target = s;
            end
            if (target < 0) begin
               // all slots busy: lfsr picks the victim, then steps once
               target      = int'(victim_lfsr % SLOT_COUNT);
               lsb         = victim_lfsr[0];
               victim_lfsr = victim_lfsr >> 1;
               if (lsb) victim_lfsr = victim_lfsr ^ LFSR_TAPS;
               r.evict_valid = 1'b1;
               r.evict_page  = tag_page[target];
            end
            tag_valid[target] = 1'b1;
            tag_page[target]  = page;
            r.status    = ST_FAULT;
            r.slot      = SLOT_W'(target);
            r.fill_page = page;
            if (!is_write) fault_total++;
         end
         r.offset = idx[OFF_W-1:0];
         if (is_write) begin
            r.write_enable = 1'b1;
            r.write_data   = wdata;
         end
      end
      r.hit_count   = hit_total;
      r.fault_count = fault_total;
      return r;
   endfunction

   always @(posedge clock) begin
      access_result_type want;
      if (reset) begin
         bound_words = '0;
         hit_total   = '0;
         fault_total = '0;
         victim_lfsr = LFSR_SEED;
         for (int s = 0; s < SLOT_COUNT; s++) begin
            tag_valid[s] = 1'b0;
            tag_page[s]  = '0;
         end
         expected_accesses.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[CSR_AW-1:2] == REG_ARRAY_SIZE) begin
            bound_words = csr_pwdata[SIZE_W-1:0];
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_accesses.push_back(predict_access(req_mon.func, req_mon.index,
                                                       req_mon.value));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_accesses.size() == 0) begin
               report_mismatch("response transfer with no access outstanding");
            end else begin
               want = expected_accesses.pop_front();
               compare_field("status", WORD_W'(rsp_mon.status), WORD_W'(want.status));
               compare_field("slot", WORD_W'(rsp_mon.slot), WORD_W'(want.slot));
               compare_field("offset", WORD_W'(rsp_mon.offset), WORD_W'(want.offset));
               compare_field("fill_page", WORD_W'(rsp_mon.fill_page), WORD_W'(want.fill_page));
               compare_field("evict_valid", WORD_W'(rsp_mon.evict_valid),
                             WORD_W'(want.evict_valid));
               compare_field("evict_page", WORD_W'(rsp_mon.evict_page),
                             WORD_W'(want.evict_page));
               compare_field("write_enable", WORD_W'(rsp_mon.write_enable),
                             WORD_W'(want.write_enable));
               compare_field("write_data", rsp_mon.write_data, want.write_data);
               compare_field("hit_count", rsp_mon.hit_count, want.hit_count);
               compare_field("fault_count", rsp_mon.fault_count, want.fault_count);
            end
         end
      end
      pending_results = expected_accesses.size();
   end

endmodule

[tb/tb_top.sv]
// top of the slot directory testbench: clock, reset, stimulus, csr writes and verdict
// depends on pasd_pkg, pasd_if.sv, the directory core and pasd_directory_checker
module tb_top;
   import pasd_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD   = 400;
   localparam int POOL_DEPTH  = 6;
   localparam int DRAIN_WAIT  = 8;

   logic clock = 1'b0;
   logic reset;

   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [WORD_W-1:0] csr_pwdata;
   logic [WORD_W-1:0] csr_prdata;
   logic              csr_pready;

   pasd_req_if req_bus ();
   pasd_rsp_if rsp_bus ();

   int pending_results;
   int mismatch_count;
   int cycle_count   = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_requests = 0;
   int holds_served  = 0;
   int hold_left     = 0;

   // small set of hot pages per phase so hits and evictions both happen often
   logic [PAGE_W-1:0] page_pool [POOL_DEPTH];

   paged_array_slot_directory_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   pasd_directory_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_pready      (csr_pready),
      .pending_results (pending_results),
      .mismatch_count  (mismatch_count)
   );

   // 20 unit period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // hard stop in case a handshake never completes
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // response side: random stalls, plus a long hold-off whenever one is requested
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_served != hold_requests) begin
            holds_served++;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // apb write: setup cycle, then access cycle until pready
   task automatic write_array_size(input logic [WORD_W-1:0] words);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_AW'({REG_ARRAY_SIZE, 2'b00});
      csr_pwdata  <= words;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // offer one access, with random idle cycles ahead of it; returns at a falling edge
   task automatic send_access(input logic is_write, input logic [WORD_W-1:0] idx,
                              input logic [WORD_W-1:0] val);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         req_bus.func  <= 1'($urandom);
         req_bus.index <= $urandom;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.func  <= is_write;
      req_bus.index <= idx;
      req_bus.value <= val;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   // sender goes quiet until every response is back, then idles before returning
   task automatic drain;
      req_bus.valid <= 1'b0;
      wait (pending_results == 0);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   // one random phase at a given array size and idle/stall mix
   task automatic run_phase(input int unsigned words, input int idle, input int stall,
                            input int count, input bit pressure);
      logic [WORD_W-1:0] idx;
      int unsigned       pick;
      drain();
      write_array_size(words);
      send_idle_pct = idle;
      stall_pct     = stall;
      for (int p = 0; p < POOL_DEPTH; p++) begin
         page_pool[p] = (words > 0) ? PAGE_W'($urandom_range(0, (words - 1) / PAGE_WORDS)) : '0;
      end
      // long receiver hold-off while accesses keep coming, so the input backs up
      if (pressure) hold_requests++;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (words > 0 && pick < 65) begin
            // hot page, random offset, clipped into range
            idx = {page_pool[$urandom_range(0, POOL_DEPTH - 1)], 7'($urandom)};
            if (idx >= words) idx = words - 1;
         end else if (words > 0 && pick < 85) begin
            idx = $urandom_range(0, words - 1);
         end else begin
            // out of range and boundary noise
            case ($urandom_range(0, 4))
               0:       idx = $urandom;
               1:       idx = {1'b1, 31'($urandom)};
               2:       idx = words;
               3:       idx = words - 1;
               default: idx = 32'h7FFF_FFFF;
            endcase
         end
         send_access(1'($urandom), idx, $urandom);
      end
   endtask

   initial begin
      reset         = 1'b1;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      req_bus.valid = 1'b0;
      req_bus.func  = 1'b0;
      req_bus.index = '0;
      req_bus.value = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: array_size still zero out of reset, so everything is out of range
      send_access(1'b0, 32'd0, 32'd0);
      send_access(1'b1, 32'hFFFF_FFFF, 32'h1234_5678);
      drain();
      write_array_size(32'd16777216);
      send_access(1'b0, 32'd0, 32'd0);              // fill of empty slot 0
      send_access(1'b0, 32'd127, 32'd0);            // hit, last offset
      send_access(1'b1, 32'd128, 32'h7FFF_FFFF);    // write miss fills slot 1, no fault count
      send_access(1'b1, 32'd16777215, 32'h8000_0000); // top page, top offset
      send_access(1'b0, 32'd16777216, 32'd0);       // index equal to array_size
      send_access(1'b0, 32'h7FFF_FFFF, 32'd0);      // far above the bound
      send_access(1'b0, 32'h8000_0000, 32'd0);      // most negative index
      send_access(1'b1, 32'd129, 32'd0);            // write hit, no hit count
      send_access(1'b0, 32'd384, 32'd0);            // last empty slot
      send_access(1'b0, 32'd640, 32'd0);            // all slots busy: lfsr victim
      send_access(1'b1, 32'd768, 32'hFFFF_FFFF);    // write miss with eviction
      send_access(1'b0, 32'd16777215, 32'd0);
      send_access(1'b0, 32'd1, 32'd0);
      send_access(1'b1, 32'd0, 32'd0);

      // random phases across array sizes and idle/stall mixes
      run_phase(32'd16777216, 0, 0, 300, 1'b0);
      run_phase(32'd640, 64, 0, 250, 1'b0);
      run_phase(32'd1, 0, 64, 100, 1'b0);
      run_phase($urandom_range(2, 16777216), 21, 21, 250, 1'b0);
      run_phase(32'd1000, 0, 0, 200, 1'b1);
      run_phase(32'd0, 21, 21, 50, 1'b0);
      run_phase(32'd16777215, 0, 0, 100, 1'b0);

      drain();
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
